// ----- rtl/address_range_symbol_lookup_assert.svh -----
// Assertion macros for the address range symbol lookup block.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef ADDRESS_RANGE_SYMBOL_LOOKUP_ASSERT_SVH
`define ADDRESS_RANGE_SYMBOL_LOOKUP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define ARSL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ARSL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ARSL_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ARSL_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/arsl_pkg.sv -----
// Shared types and constants for the address range symbol lookup block.
// No dependencies.
package arsl_pkg;
  localparam int SYM_ENTRIES  = 256;
  localparam int SYM_AW       = 8;
  localparam int FILE_ENTRIES = 64;
  localparam int FILE_AW      = 6;

  typedef enum logic [1:0] {
    OP_BEGIN  = 2'd0,
    OP_SYMBOL = 2'd1,
    OP_FILE   = 2'd2,
    OP_LOOKUP = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DUP  = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_BS, S_BSC, S_CHK, S_INS, S_SH_RD, S_SH_WR, S_FS, S_FSC, S_DONE
  } state_t;

  typedef struct packed {
    logic [63:0] start;
    logic [31:0] len;
    logic [15:0] name;
    logic [15:0] file;
    logic [31:0] line;
  } sym_entry_t;

  typedef struct packed {
    logic [15:0] key;
    logic [15:0] path;
  } file_entry_t;
endpackage

// ----- rtl/address_range_symbol_lookup.sv -----
// Top level of the address range symbol lookup block.
// Depends on arsl_pkg and address_range_symbol_lookup_assert.svh.
//
// Usage: one transaction on the in_ channel carries an op and its fields;
// each gives exactly one transaction on the out_ channel. Symbols live in a
// sorted single-port-read memory, files in a second memory.
// Steps per op, one item at a time:
//   begin_module: no memory steps.
//   lookup: binary-search steps (up to 9 steps for 256
//   entries), a candidate read, then one step per file entry scanned.
//   insert_symbol: search as above, then one step per entry moved up to
//   open the slot, then the final write.
//   insert_file: one step per file entry scanned for a duplicate key.
// Each memory step is a read state, then a compare or write state on the
// registered read data. A new item is taken once the previous result sits
// in the output register; a stalled receiver holds that result and, once
// the next item is done, the block waits for the register to drain.
// Reset empties both tables (counts to zero) and clears the module base.
`include "address_range_symbol_lookup_assert.svh"
module address_range_symbol_lookup import arsl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [63:0] in_address,
  input  logic [31:0] in_rva,
  input  logic [31:0] in_sym_size,
  input  logic [15:0] in_name_handle,
  input  logic [15:0] in_local_file_id,
  input  logic [31:0] in_line_number,
  input  logic [15:0] in_path_handle,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic        out_sym_hit,
  output logic [15:0] out_hit_name,
  output logic        out_file_hit,
  output logic [15:0] out_hit_path,
  output logic [31:0] out_hit_line
);
  sym_entry_t sym_mem [SYM_ENTRIES];
  file_entry_t file_mem [FILE_ENTRIES];
  sym_entry_t sym_rdata_r, sym_wdata;
  file_entry_t file_rdata_r, file_wdata;
  logic sym_re, sym_we, file_re, file_we;
  logic [SYM_AW-1:0] sym_raddr, sym_waddr;
  logic [FILE_AW-1:0] file_raddr, file_waddr;

  state_t state_r, state_nxt;
  logic [SYM_AW:0] sym_count_r, sym_count_nxt;
  logic [FILE_AW:0] file_count_r, file_count_nxt;
  logic [63:0] module_base_r, module_base_nxt;
  logic [15:0] file_base_r, file_base_nxt;
  logic [15:0] file_max_r, file_max_nxt;
  logic [SYM_AW:0] lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt, idx_r, idx_nxt;
  logic [FILE_AW:0] fidx_r, fidx_nxt;
  logic [1:0] op_r, op_nxt;
  logic [63:0] addr_r, addr_nxt;
  logic [31:0] size_r, size_nxt;
  logic [15:0] name_r, name_nxt, rfile_r, rfile_nxt, path_r, path_nxt;
  logic [31:0] line_r, line_nxt;
  logic [15:0] key_r, key_nxt;
  logic [1:0] res_status_r, res_status_nxt;
  logic res_sym_hit_r, res_sym_hit_nxt, res_file_hit_r, res_file_hit_nxt;
  logic [15:0] res_name_r, res_name_nxt, res_path_r, res_path_nxt;
  logic [31:0] res_line_r, res_line_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [1:0] out_status_r;
  logic out_sym_hit_r, out_file_hit_r;
  logic [15:0] out_hit_name_r, out_hit_path_r;
  logic [31:0] out_hit_line_r;
  logic out_load;
  logic [SYM_AW:0] mid;
  logic [63:0] diff;

  always_ff @(posedge clk) begin
    if (sym_we) sym_mem[sym_waddr] <= sym_wdata;
    if (sym_re) sym_rdata_r <= sym_mem[sym_raddr];
    if (file_we) file_mem[file_waddr] <= file_wdata;
    if (file_re) file_rdata_r <= file_mem[file_raddr];
  end

  assign mid  = lo_r + ((hi_r - lo_r) >> 1);
  assign diff = addr_r - sym_rdata_r.start;
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    sym_count_nxt = sym_count_r;
    file_count_nxt = file_count_r;
    module_base_nxt = module_base_r;
    file_base_nxt = file_base_r;
    file_max_nxt = file_max_r;
    lo_nxt = lo_r; hi_nxt = hi_r; mid_nxt = mid_r; idx_nxt = idx_r;
    fidx_nxt = fidx_r;
    op_nxt = op_r; addr_nxt = addr_r; size_nxt = size_r; name_nxt = name_r;
    rfile_nxt = rfile_r; path_nxt = path_r; line_nxt = line_r; key_nxt = key_r;
    res_status_nxt = res_status_r; res_sym_hit_nxt = res_sym_hit_r;
    res_file_hit_nxt = res_file_hit_r; res_name_nxt = res_name_r;
    res_path_nxt = res_path_r; res_line_nxt = res_line_r;
    sym_re = 1'b0; sym_we = 1'b0; file_re = 1'b0; file_we = 1'b0;
    sym_raddr = mid[SYM_AW-1:0];
    sym_waddr = idx_r[SYM_AW-1:0];
    sym_wdata = sym_rdata_r;
    file_raddr = fidx_r[FILE_AW-1:0];
    file_waddr = file_count_r[FILE_AW-1:0];
    file_wdata = '{key: key_r, path: path_r};
    out_load = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt = in_op;
          addr_nxt = (in_op == OP_SYMBOL) ? module_base_r + {32'd0, in_rva} : in_address;
          size_nxt = in_sym_size;
          name_nxt = in_name_handle;
          rfile_nxt = file_base_r + in_local_file_id;
          key_nxt = file_base_r + in_local_file_id;
          path_nxt = in_path_handle;
          line_nxt = in_line_number;
          res_status_nxt = ST_OK; res_sym_hit_nxt = 1'b0; res_file_hit_nxt = 1'b0;
          res_name_nxt = '0; res_path_nxt = '0; res_line_nxt = '0;
          lo_nxt = '0; hi_nxt = sym_count_r; fidx_nxt = '0;
          case (in_op)
            OP_BEGIN: begin
              module_base_nxt = in_address;
              file_base_nxt = file_max_r;
              state_nxt = S_DONE;
            end
            OP_FILE: state_nxt = S_FS;
            default: state_nxt = S_BS;
          endcase
        end
      end
      S_BS: begin
        if (lo_r < hi_r) begin
          sym_re = 1'b1;
          mid_nxt = mid;
          state_nxt = S_BSC;
        end else if (lo_r == '0) begin
          state_nxt = (op_r == OP_SYMBOL) ? S_INS : S_DONE;
        end else begin
          sym_re = 1'b1;
          sym_raddr = SYM_AW'(lo_r - 1'b1);
          state_nxt = S_CHK;
        end
      end
      S_BSC: begin
        if (sym_rdata_r.start <= addr_r) lo_nxt = mid_r + 1'b1;
        else hi_nxt = mid_r;
        state_nxt = S_BS;
      end
      S_CHK: begin
        if (op_r == OP_SYMBOL) begin
          if (sym_rdata_r.start == addr_r) begin
            res_status_nxt = ST_DUP;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_INS;
          end
        end else if (diff < {32'd0, sym_rdata_r.len}) begin
          res_sym_hit_nxt = 1'b1;
          res_name_nxt = sym_rdata_r.name;
          line_nxt = sym_rdata_r.line;
          key_nxt = sym_rdata_r.file;
          fidx_nxt = '0;
          state_nxt = S_FS;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_INS: begin
        if (sym_count_r == (SYM_AW+1)'(SYM_ENTRIES)) begin
          res_status_nxt = ST_FULL;
          state_nxt = S_DONE;
        end else begin
          idx_nxt = sym_count_r;
          state_nxt = S_SH_RD;
        end
      end
      S_SH_RD: begin
        if (idx_r > lo_r) begin
          sym_re = 1'b1;
          sym_raddr = SYM_AW'(idx_r - 1'b1);
          state_nxt = S_SH_WR;
        end else begin
          sym_we = 1'b1;
          sym_waddr = lo_r[SYM_AW-1:0];
          sym_wdata = '{start: addr_r, len: size_r, name: name_r, file: rfile_r,
                        line: line_r};
          sym_count_nxt = sym_count_r + 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_SH_WR: begin
        sym_we = 1'b1;
        idx_nxt = idx_r - 1'b1;
        state_nxt = S_SH_RD;
      end
      S_FS: begin
        if (fidx_r < file_count_r) begin
          file_re = 1'b1;
          state_nxt = S_FSC;
        end else begin
          if (op_r == OP_FILE) begin
            if (file_count_r == (FILE_AW+1)'(FILE_ENTRIES)) begin
              res_status_nxt = ST_FULL;
            end else begin
              file_we = 1'b1;
              file_count_nxt = file_count_r + 1'b1;
              if (key_r > file_max_r) file_max_nxt = key_r;
            end
          end
          state_nxt = S_DONE;
        end
      end
      S_FSC: begin
        if (file_rdata_r.key == key_r) begin
          if (op_r == OP_FILE) begin
            res_status_nxt = ST_DUP;
          end else begin
            res_file_hit_nxt = 1'b1;
            res_path_nxt = file_rdata_r.path;
            res_line_nxt = line_r;
          end
          state_nxt = S_DONE;
        end else begin
          fidx_nxt = fidx_r + 1'b1;
          state_nxt = S_FS;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      sym_count_r <= '0;
      file_count_r <= '0;
      module_base_r <= '0;
      file_base_r <= '0;
      file_max_r <= '0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
      sym_count_r <= sym_count_nxt;
      file_count_r <= file_count_nxt;
      module_base_r <= module_base_nxt;
      file_base_r <= file_base_nxt;
      file_max_r <= file_max_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r <= lo_nxt; hi_r <= hi_nxt; mid_r <= mid_nxt; idx_r <= idx_nxt;
    fidx_r <= fidx_nxt;
    op_r <= op_nxt; addr_r <= addr_nxt; size_r <= size_nxt; name_r <= name_nxt;
    rfile_r <= rfile_nxt; path_r <= path_nxt; line_r <= line_nxt; key_r <= key_nxt;
    res_status_r <= res_status_nxt; res_sym_hit_r <= res_sym_hit_nxt;
    res_file_hit_r <= res_file_hit_nxt; res_name_r <= res_name_nxt;
    res_path_r <= res_path_nxt; res_line_r <= res_line_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_sym_hit_r <= res_sym_hit_r;
      out_hit_name_r <= res_name_r;
      out_file_hit_r <= res_file_hit_r;
      out_hit_path_r <= res_path_r;
      out_hit_line_r <= res_line_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_status = out_status_r;
  assign out_sym_hit = out_sym_hit_r;
  assign out_hit_name = out_hit_name_r;
  assign out_file_hit = out_file_hit_r;
  assign out_hit_path = out_hit_path_r;
  assign out_hit_line = out_hit_line_r;

  `ARSL_ASSERT_IMP(a_sym_count, clk, rst_n, 1'b1, sym_count_r <= (SYM_AW+1)'(SYM_ENTRIES))
  `ARSL_ASSERT_IMP(a_file_count, clk, rst_n, 1'b1, file_count_r <= (FILE_AW+1)'(FILE_ENTRIES))
  `ARSL_ASSERT_NXT(a_busy, clk, rst_n, in_valid && in_ready, state_r != S_IDLE)
  `ARSL_ASSERT_IMP(a_file_hit, clk, rst_n, out_valid && out_file_hit, out_sym_hit)
endmodule
